// ===== rtl/wlfa_pkg.sv =====
// Package with the shared types and constants of the water level flood alarm.
package wlfa_pkg;

    localparam int unsigned DIST_W  = 19;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned SEC_W   = 32;
    localparam int unsigned ECHO_W  = 15;

    localparam logic [ECHO_W-1:0] ECHO_TIMEOUT_US = 15'd30000;
    localparam logic [4:0]        DIST_PER_US     = 5'd17;

    // Rounding offset and reciprocal for a ceiling division by 1000.
    localparam logic [9:0]  MILLI_ROUND = 10'd999;
    localparam logic [19:0] MILLI_RECIP = 20'd536871;
    localparam int unsigned MILLI_SHIFT = 29;
    localparam logic [9:0]  MILLI       = 10'd1000;

    // Reciprocal for a division by 15, applied after a shift by two.
    localparam logic [20:0] FIFTEEN_RECIP = 21'd1118482;
    localparam int unsigned FIFTEEN_SHIFT = 24;
    localparam logic [SEC_W-1:0] MIN_SAT_SECONDS = 32'd3932160;

    localparam logic [2:0] CFG_THRESHOLD    = 3'd0;
    localparam logic [2:0] CFG_HEIGHT       = 3'd1;
    localparam logic [2:0] CFG_SAMPLE_INT   = 3'd2;
    localparam logic [2:0] CFG_BLINK_HALF   = 3'd3;
    localparam logic [2:0] CFG_BUZZ_ON      = 3'd4;
    localparam logic [2:0] CFG_BUZZ_PERIOD  = 3'd5;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_END   = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic               high;
        logic [LEVEL_W-1:0] level_cm;
    } t_level_res;

endpackage

// ===== rtl/wlfa_level.sv =====
// Water level computation from the echo distance and the threshold compare.
module wlfa_level (
    input  logic [wlfa_pkg::DIST_W-1:0]  i_dist,
    input  logic [7:0]                   i_height_cm,
    input  logic [7:0]                   i_threshold_cm,
    output wlfa_pkg::t_level_res         o_res
);

    logic [17:0] w_full;
    logic [17:0] w_thr_milli;
    logic [19:0] w_need;
    logic [18:0] w_dist_up;
    logic [38:0] w_prod;
    logic [9:0]  w_dist_cm;

    assign w_full      = 18'(i_height_cm) * 18'(wlfa_pkg::MILLI);
    assign w_thr_milli = 18'(i_threshold_cm) * 18'(wlfa_pkg::MILLI);
    assign w_need      = 20'(i_dist) + 20'(w_thr_milli);
    assign w_dist_up   = i_dist + 19'(wlfa_pkg::MILLI_ROUND);
    assign w_prod      = 39'(w_dist_up) * 39'(wlfa_pkg::MILLI_RECIP);
    assign w_dist_cm   = w_prod[38:wlfa_pkg::MILLI_SHIFT];

    always_comb begin
        o_res.high = (i_threshold_cm == 8'd0) || (w_need <= 20'(w_full));
        if (w_dist_cm >= 10'(i_height_cm)) begin
            o_res.level_cm = '0;
        end else begin
            o_res.level_cm = i_height_cm - w_dist_cm[7:0];
        end
    end

endmodule

// ===== rtl/wlfa_minutes.sv =====
// Flood duration in whole minutes, saturated to sixteen bits.
module wlfa_minutes (
    input  logic [wlfa_pkg::SEC_W-1:0] i_now,
    input  logic [wlfa_pkg::SEC_W-1:0] i_start,
    output logic [15:0]                o_minutes
);

    logic [wlfa_pkg::SEC_W-1:0] w_diff;
    logic [19:0]                w_quarter;
    logic [40:0]                w_prod;

    assign w_diff    = i_now - i_start;
    assign w_quarter = w_diff[21:2];
    assign w_prod    = 41'(w_quarter) * 41'(wlfa_pkg::FIFTEEN_RECIP);

    always_comb begin
        if (w_diff >= wlfa_pkg::MIN_SAT_SECONDS) begin
            o_minutes = 16'hFFFF;
        end else begin
            o_minutes = w_prod[wlfa_pkg::FIFTEEN_SHIFT+15:wlfa_pkg::FIFTEEN_SHIFT];
        end
    end

endmodule

// ===== rtl/water_level_flood_alarm_unit.sv =====
// Top level of the water level flood alarm with stream ports and a register write port.
// Pipeline: two register stages (input register, result register), with the level and minute
// reciprocal multiplies between them. Throughput: one tick item per clock cycle while
// m_axis_tready does not stall the output; the alarm state updates once per item.
// Reset: synchronous, active low; clears the alarm state, both pipeline valid flags and
// loads the default register values.
module water_level_flood_alarm_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // echo_us[14:0], now_seconds[46:15], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // led_on[0], buzzer_on[1], flood_active[2], level_cm[10:3], duration_min[26:11],
    // event_seconds[58:27], zero fill
    output logic [63:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // event_kind[1:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    logic [7:0]  r_threshold;
    logic [7:0]  r_height;
    logic [15:0] r_sample_int;
    logic [15:0] r_blink_half;
    logic [15:0] r_buzz_on;
    logic [15:0] r_buzz_period;

    logic                          r_in_valid;
    logic [wlfa_pkg::DIST_W-1:0]   r_dist;
    logic [wlfa_pkg::SEC_W-1:0]    r_now;
    logic [wlfa_pkg::ECHO_W-1:0]   w_echo;
    logic [wlfa_pkg::ECHO_W-1:0]   w_echo_clip;
    logic [wlfa_pkg::DIST_W-1:0]   w_dist;

    logic        r_flood, n_flood;
    logic        r_led, n_led;
    logic        r_buzz, n_buzz;
    logic        r_first, n_first;
    logic [15:0] r_since_sample, n_since_sample;
    logic [15:0] r_since_blink, n_since_blink;
    logic [15:0] r_since_buzz, n_since_buzz;
    logic [31:0] r_start_sec, n_start_sec;
    logic [7:0]  r_last_level, n_last_level;

    wlfa_pkg::t_event_kind n_kind;
    logic [15:0]           n_dur;
    logic [31:0]           n_evs;

    logic        r_out_valid;
    logic        r_out_led;
    logic        r_out_buzz;
    logic        r_out_flood;
    logic [1:0]  r_out_kind;
    logic [7:0]  r_out_level;
    logic [15:0] r_out_dur;
    logic [31:0] r_out_evs;

    wlfa_pkg::t_level_res w_level;
    logic [15:0]          w_minutes;
    logic                 w_adv;
    logic                 w_step;
    logic                 w_sample_due;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= 8'd30;
            r_height      <= 8'd100;
            r_sample_int  <= 16'd10000;
            r_blink_half  <= 16'd500;
            r_buzz_on     <= 16'd5000;
            r_buzz_period <= 16'd15000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wlfa_pkg::CFG_THRESHOLD:   r_threshold   <= i_cfg_data[7:0];
                wlfa_pkg::CFG_HEIGHT:      r_height      <= i_cfg_data[7:0];
                wlfa_pkg::CFG_SAMPLE_INT:  r_sample_int  <= i_cfg_data;
                wlfa_pkg::CFG_BLINK_HALF:  r_blink_half  <= i_cfg_data;
                wlfa_pkg::CFG_BUZZ_ON:     r_buzz_on     <= i_cfg_data;
                wlfa_pkg::CFG_BUZZ_PERIOD: r_buzz_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    assign w_echo      = s_axis_tdata[14:0];
    assign w_echo_clip = (w_echo > wlfa_pkg::ECHO_TIMEOUT_US) ? '0 : w_echo;
    assign w_dist      = 19'(w_echo_clip) * 19'(wlfa_pkg::DIST_PER_US);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_dist <= w_dist;
            r_now  <= s_axis_tdata[46:15];
        end
    end

    wlfa_level u_level (
        .i_dist         (r_dist),
        .i_height_cm    (r_height),
        .i_threshold_cm (r_threshold),
        .o_res          (w_level)
    );

    wlfa_minutes u_minutes (
        .i_now     (r_now),
        .i_start   (r_start_sec),
        .o_minutes (w_minutes)
    );

    assign w_sample_due = r_first || (r_since_sample >= r_sample_int);

    always_comb begin
        n_led          = r_led;
        n_buzz         = r_buzz;
        n_since_blink  = r_since_blink;
        n_since_buzz   = r_since_buzz;
        n_flood        = r_flood;
        n_first        = r_first;
        n_since_sample = r_since_sample;
        n_start_sec    = r_start_sec;
        n_last_level   = r_last_level;
        n_kind         = wlfa_pkg::EV_NONE;
        n_dur          = '0;
        n_evs          = '0;

        if (r_flood) begin
            if (r_since_blink >= r_blink_half) begin
                n_since_blink = '0;
                n_led         = ~r_led;
            end
            if (!r_buzz && (r_since_buzz >= r_buzz_period)) begin
                n_buzz       = 1'b1;
                n_since_buzz = '0;
            end
            if (n_buzz && (n_since_buzz >= r_buzz_on)) begin
                n_buzz = 1'b0;
            end
        end else begin
            n_led        = 1'b0;
            n_buzz       = 1'b0;
            n_since_buzz = '0;
        end

        if (w_sample_due) begin
            n_since_sample = '0;
            n_first        = 1'b0;
            n_last_level   = w_level.level_cm;
            if (w_level.high && !r_flood) begin
                n_flood      = 1'b1;
                n_start_sec  = r_now;
                n_since_buzz = r_buzz_period;
                n_kind       = wlfa_pkg::EV_START;
                n_evs        = r_now;
            end else if (!w_level.high && r_flood) begin
                n_flood = 1'b0;
                n_buzz  = 1'b0;
                n_dur   = w_minutes;
                n_kind  = wlfa_pkg::EV_END;
                n_evs   = r_now;
            end
        end

        n_since_sample = sat_inc(n_since_sample);
        n_since_blink  = sat_inc(n_since_blink);
        n_since_buzz   = sat_inc(n_since_buzz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flood        <= 1'b0;
            r_led          <= 1'b0;
            r_buzz         <= 1'b0;
            r_first        <= 1'b1;
            r_since_sample <= '0;
            r_since_blink  <= '0;
            r_since_buzz   <= '0;
            r_start_sec    <= '0;
            r_last_level   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_flood        <= n_flood;
                r_led          <= n_led;
                r_buzz         <= n_buzz;
                r_first        <= n_first;
                r_since_sample <= n_since_sample;
                r_since_blink  <= n_since_blink;
                r_since_buzz   <= n_since_buzz;
                r_start_sec    <= n_start_sec;
                r_last_level   <= n_last_level;
            end
        end
        if (w_step) begin
            r_out_led   <= n_led;
            r_out_buzz  <= n_buzz;
            r_out_flood <= n_flood;
            r_out_kind  <= n_kind;
            r_out_level <= n_last_level;
            r_out_dur   <= n_dur;
            r_out_evs   <= n_evs;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {5'd0, r_out_evs, r_out_dur, r_out_level,
                            r_out_flood, r_out_buzz, r_out_led};

    a_buzz_needs_flood: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buzz |-> r_flood)
        else $error("buzzer state is set without an active flood");

    a_start_sets_flood: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == wlfa_pkg::EV_START)) |-> m_axis_tdata[2])
        else $error("flood start result without flood_active");

    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> m_axis_tvalid)
        else $error("processed item did not produce a result");

endmodule
